### hdl/epx_pkg.sv
package epx_pkg;

  localparam int PIX_BITS       = 32;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
  localparam int CFG_BITS       = 11;
  localparam int ROW_BITS       = 11;
  localparam int COORD_BITS     = 10;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET   = CFG_BITS'(320);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(224);

  typedef logic [PIX_BITS-1:0]   pixel_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CFG_BITS-1:0]   cfg_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   emit;
    logic   wr_centre;
    logic   wr_older;
    logic   first;
    logic   flush;
    logic   last;
    logic   self_fwd;
    addr_t  x;
    coord_t row;
  } stage_ctl_t;

endpackage

### hdl/epx_in_if.sv
interface epx_in_if import epx_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t src_pixel;
  logic   drain;

  modport source (output valid, output src_pixel, output drain, input ready);
  modport sink (input valid, input src_pixel, input drain, output ready);
endinterface

### hdl/epx_out_if.sv
interface epx_out_if import epx_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t top_left;
  pixel_t top_right;
  pixel_t bottom_left;
  pixel_t bottom_right;
  coord_t out_col;
  coord_t out_row;
  logic   frame_end;

  modport source (
    output valid, output top_left, output top_right, output bottom_left,
    output bottom_right, output out_col, output out_row, output frame_end,
    input ready
  );
  modport sink (
    input valid, input top_left, input top_right, input bottom_left,
    input bottom_right, input out_col, input out_row, input frame_end,
    output ready
  );
endinterface

### hdl/epx_pixel_doubler.sv
// EPX 2x pixel doubler for a raster pixel stream.
// src: one transaction per source pixel, in raster order. After the last
//   source line, send one line of transactions with drain set to flush it.
//   A drain transaction outside the flush line is dropped.
// dst: one transaction per 2x2 output block, for the centre one line above
//   the pixel just taken; out_col/out_row locate it, frame_end marks the
//   last block of the frame. The first source line gives no output.
// cfg: cfg_wr_en/cfg_index/cfg_data write line_width (index 0) or
//   frame_height (index 1); write only while the block is idle.
// Throughput: one transaction per cycle while dst is not stalled, set by
//   the two line memories (older and centre line), each read once and
//   written once per cycle.
// Path: a taken pixel is registered in the internal stage, then on dst.
// Stall: a stalled dst holds its block; src keeps flowing until the
//   internal stage also fills, then src.ready drops.
// Reset (rst, synchronous): counters clear, registers return to 320x224;
//   line memory contents are not cleared and need no clearing pass.
module epx_pixel_doubler import epx_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  epx_in_if.sink                    src,
  epx_out_if.source                 dst
);

  pixel_t older_mem  [MAX_WIDTH];
  pixel_t centre_mem [MAX_WIDTH];

  cfg_t       line_width;
  cfg_t       frame_height;
  addr_t      column_count;
  row_t       row_count;
  cfg_t       w_eff;
  cfg_t       h_eff;
  cfg_t       x_inc;
  logic       last;
  logic       flush;
  logic       take;
  addr_t      raddr_centre;
  stage_ctl_t ctl_next;
  row_t       row_dec;

  logic       b_valid;
  logic       b_adv;
  stage_ctl_t b_ctl;
  pixel_t     b_p;
  pixel_t     centre_q;
  pixel_t     older_q;
  logic       fwd_centre;
  logic       fwd_older;
  pixel_t     fwd_centre_data;
  pixel_t     fwd_older_data;
  logic       wr_centre;
  logic       wr_older;
  pixel_t     c_hold;
  pixel_t     left_hold;

  pixel_t     cen, up, dn, lf, rt;
  pixel_t     centre_r, older_r;
  logic       out_free;
  logic       out_valid;

  always_comb begin
    if (line_width == '0) begin
      w_eff = cfg_t'(1);
    end else if (line_width > cfg_t'(MAX_WIDTH)) begin
      w_eff = cfg_t'(MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    if (frame_height == '0) begin
      h_eff = cfg_t'(1);
    end else if (frame_height > cfg_t'(MAX_HEIGHT)) begin
      h_eff = cfg_t'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign x_inc        = cfg_t'(column_count) + cfg_t'(1);
  assign last         = x_inc >= w_eff;
  assign flush        = cfg_t'(row_count) >= h_eff;
  assign take         = src.valid && src.ready && !(src.drain && !flush);
  assign raddr_centre = last ? '0 : column_count + addr_t'(1);
  assign row_dec      = row_count - row_t'(1);

  always_comb begin
    ctl_next.emit      = (row_count != '0);
    ctl_next.wr_centre = (row_count == '0) || !flush;
    ctl_next.wr_older  = (row_count != '0) && !flush;
    ctl_next.first     = (row_count == row_t'(1));
    ctl_next.flush     = flush;
    ctl_next.last      = last;
    ctl_next.self_fwd  = last && (column_count == '0) && ctl_next.wr_centre;
    ctl_next.x         = column_count;
    ctl_next.row       = row_dec[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (last) begin
        column_count <= '0;
        if (row_count == '0) begin
          row_count <= row_t'(1);
        end else if (flush) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + row_t'(1);
        end
      end else begin
        column_count <= column_count + addr_t'(1);
      end
    end
  end

  assign out_free  = !out_valid || dst.ready;
  assign b_adv     = b_valid && (!b_ctl.emit || out_free);
  assign src.ready = !b_valid || b_adv;
  assign wr_centre = b_adv && b_ctl.wr_centre;
  assign wr_older  = b_adv && b_ctl.wr_older;

  always_ff @(posedge clk) begin
    if (wr_centre) begin
      centre_mem[b_ctl.x] <= b_p;
    end
    if (take) begin
      centre_q <= centre_mem[raddr_centre];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_older) begin
      older_mem[b_ctl.x] <= c_hold;
    end
    if (take) begin
      older_q <= older_mem[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_ctl           <= ctl_next;
      b_p             <= src.src_pixel;
      fwd_centre      <= wr_centre && (b_ctl.x == raddr_centre);
      fwd_older       <= wr_older && (b_ctl.x == column_count);
      fwd_centre_data <= b_p;
      fwd_older_data  <= c_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  assign centre_r = fwd_centre ? fwd_centre_data : centre_q;
  assign older_r  = fwd_older ? fwd_older_data : older_q;

  always_comb begin
    cen = c_hold;
    up  = b_ctl.first ? cen : older_r;
    dn  = b_ctl.flush ? cen : b_p;
    lf  = (b_ctl.x == '0) ? cen : left_hold;
    rt  = b_ctl.last ? cen : centre_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_hold    <= '0;
      left_hold <= '0;
    end else if (b_adv) begin
      c_hold <= b_ctl.self_fwd ? b_p : centre_r;
      if (b_ctl.emit) begin
        left_hold <= c_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_ctl.emit) begin
      if (lf != rt && up != dn) begin
        dst.top_left     <= (up == lf) ? up : cen;
        dst.top_right    <= (rt == up) ? rt : cen;
        dst.bottom_left  <= (lf == dn) ? lf : cen;
        dst.bottom_right <= (dn == rt) ? dn : cen;
      end else begin
        dst.top_left     <= cen;
        dst.top_right    <= cen;
        dst.bottom_left  <= cen;
        dst.bottom_right <= cen;
      end
      dst.out_col   <= COORD_BITS'(b_ctl.x);
      dst.out_row   <= b_ctl.row;
      dst.frame_end <= b_ctl.flush && b_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv && b_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign dst.valid = out_valid;

`ifndef SYNTHESIS
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !src.ready |-> (b_valid && b_ctl.emit && out_valid && !dst.ready))
    else $error("src stalled while pipeline has room");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_adv) |=> (b_valid && $stable(b_ctl) && $stable(b_p)))
    else $error("internal stage changed while stalled");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_adv && b_ctl.emit))
    else $error("output became valid without a block leaving the stage");
`endif

endmodule

### tb/tb_epx_pixel_doubler.sv
module tb_epx_pixel_doubler import epx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t top_left;
    pixel_t top_right;
    pixel_t bottom_left;
    pixel_t bottom_right;
    coord_t col;
    coord_t row;
    logic   frame_end;
  } epx_block_t;

  class block_tracker;
    pixel_t     older_line [MAX_WIDTH];
    pixel_t     centre_line [MAX_WIDTH];
    addr_t      col_cnt;
    row_t       row_cnt;
    pixel_t     left_px;
    cfg_t       width_reg;
    cfg_t       height_reg;
    epx_block_t pending_blocks [$];
    int         mismatches;
    int         blocks_seen;

    function new();
      col_cnt     = '0;
      row_cnt     = '0;
      left_px     = '0;
      width_reg   = LINE_WIDTH_RESET;
      height_reg  = FRAME_HEIGHT_RESET;
      mismatches  = 0;
      blocks_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, cfg_t val);
      if (idx == REG_LINE_WIDTH) begin
        width_reg = val;
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function void take_pixel(pixel_t pix, logic drn);
      int         w;
      int         h;
      int         x;
      bit         last;
      bit         flush;
      pixel_t     c;
      pixel_t     u;
      pixel_t     d;
      pixel_t     l;
      pixel_t     r;
      epx_block_t blk;
      w    = active_width();
      h    = active_height();
      x    = int'(col_cnt);
      last = (x + 1) >= w;
      if (drn && int'(row_cnt) < h) return;
      if (row_cnt == 0) begin
        centre_line[x] = pix;
        if (last) begin
          col_cnt = '0;
          row_cnt = row_t'(1);
        end else begin
          col_cnt = addr_t'(x + 1);
        end
        return;
      end
      flush = int'(row_cnt) >= h;
      c = centre_line[x];
      u = (row_cnt == 1) ? c : older_line[x];
      d = flush ? c : pix;
      l = (x == 0) ? c : left_px;
      r = last ? c : centre_line[x + 1];
      blk.top_left     = c;
      blk.top_right    = c;
      blk.bottom_left  = c;
      blk.bottom_right = c;
      if (l != r && u != d) begin
        blk.top_left     = (u == l) ? u : c;
        blk.top_right    = (r == u) ? r : c;
        blk.bottom_left  = (l == d) ? l : c;
        blk.bottom_right = (d == r) ? d : c;
      end
      blk.col       = coord_t'(x);
      blk.row       = coord_t'(int'(row_cnt) - 1);
      blk.frame_end = flush && last;
      pending_blocks.push_back(blk);
      if (!flush) begin
        older_line[x]  = c;
        centre_line[x] = pix;
      end
      left_px = c;
      if (last) begin
        col_cnt = '0;
        row_cnt = flush ? row_t'(0) : row_t'(int'(row_cnt) + 1);
      end else begin
        col_cnt = addr_t'(x + 1);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task diff(string field, logic [31:0] got, logic [31:0] want, int col, int row);
      if (got !== want)
        report($sformatf("%s = %h, want %h (col %0d row %0d)", field, got, want, col, row));
    endtask

    task check_block(epx_block_t got);
      epx_block_t want;
      blocks_seen++;
      if (pending_blocks.size() == 0) begin
        report($sformatf("block at col %0d row %0d with none expected", got.col, got.row));
        return;
      end
      want = pending_blocks.pop_front();
      diff("top_left", got.top_left, want.top_left, want.col, want.row);
      diff("top_right", got.top_right, want.top_right, want.col, want.row);
      diff("bottom_left", got.bottom_left, want.bottom_left, want.col, want.row);
      diff("bottom_right", got.bottom_right, want.bottom_right, want.col, want.row);
      diff("out_col", 32'(got.col), 32'(want.col), want.col, want.row);
      diff("out_row", 32'(got.row), 32'(want.row), want.col, want.row);
      diff("frame_end", 32'(got.frame_end), 32'(want.frame_end), want.col, want.row);
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  cfg_t                      cfg_data;

  epx_in_if  src_if ();
  epx_out_if dst_if ();

  epx_pixel_doubler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_if),
    .dst       (dst_if)
  );

  block_tracker tracker = new();

  bit     hold_req   = 1'b0;
  int     hold_left  = 0;
  int     stall_mode = 0;
  int     mode_left  = 0;
  int     burst_left = 0;
  int     items_fed  = 0;
  int     frames_fed = 0;
  int     s_w        = 320;
  int     s_h        = 224;
  int     s_col      = 0;
  int     s_row      = 0;
  pixel_t palette [4];
  pixel_t script [$];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin : watch
    epx_block_t got;
    if (!rst) begin
      if (cfg_wr_en) tracker.write_reg(cfg_index, cfg_data);
      if (dst_if.valid && dst_if.ready) begin
        got.top_left     = dst_if.top_left;
        got.top_right    = dst_if.top_right;
        got.bottom_left  = dst_if.bottom_left;
        got.bottom_right = dst_if.bottom_right;
        got.col          = dst_if.out_col;
        got.row          = dst_if.out_row;
        got.frame_end    = dst_if.frame_end;
        tracker.check_block(got);
      end
      if (src_if.valid && src_if.ready) tracker.take_pixel(src_if.src_pixel, src_if.drain);
    end
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      dst_if.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      hold_left    = 160;
      dst_if.ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 120);
      end
      mode_left--;
      case (stall_mode)
        0: dst_if.ready = 1'b1;
        1: dst_if.ready = ($urandom_range(0, 9) < 7);
        2: dst_if.ready = ($urandom_range(0, 9) < 3);
        default: dst_if.ready = ~dst_if.ready;
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int clamp_cfg(int val, int top);
    if (val == 0) return 1;
    if (val > top) return top;
    return val;
  endfunction

  function automatic pixel_t next_pixel();
    if (script.size() != 0) return script.pop_front();
    if ($urandom_range(0, 15) == 0) return pixel_t'($urandom);
    return palette[$urandom_range(0, 3)];
  endfunction

  task automatic new_palette();
    int k;
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: palette[k] = '0;
        1: palette[k] = '1;
        default: palette[k] = pixel_t'($urandom);
      endcase
    end
  endtask

  task automatic drive(pixel_t pix, logic drn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        src_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    src_if.valid     = 1'b1;
    src_if.src_pixel = pix;
    src_if.drain     = drn;
    do @(posedge clk); while (!src_if.ready);
  endtask

  task automatic feed_item();
    bit flush;
    flush = s_row >= s_h;
    if (flush) begin
      drive(next_pixel(), $urandom_range(0, 7) != 0);
    end else begin
      if ($urandom_range(0, 15) == 0) drive(pixel_t'($urandom), 1'b1);
      drive(next_pixel(), 1'b0);
    end
    items_fed++;
    if (items_fed % 450 == 200) hold_req = 1'b1;
    if (s_col + 1 >= s_w) begin
      s_col = 0;
      s_row = flush ? 0 : s_row + 1;
      if (s_row == 0) frames_fed++;
    end else begin
      s_col++;
    end
  endtask

  task automatic feed_frame();
    do feed_item(); while (!(s_row == 0 && s_col == 0));
  endtask

  // drop valid and hold until every block has come out
  task automatic settle();
    @(negedge clk);
    src_if.valid = 1'b0;
    burst_left = 0;
    while (tracker.pending_blocks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = cfg_t'(val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_LINE_WIDTH) s_w = clamp_cfg(val & 'h7ff, MAX_WIDTH);
    else s_h = clamp_cfg(val & 'h7ff, MAX_HEIGHT);
  endtask

  task automatic set_frame(int w, int h);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_LINE_WIDTH, w);
    end
  endtask

  initial begin : stimulus
    pixel_t pa;
    pixel_t pb;
    pixel_t pc;
    pixel_t pd;
    int     w;
    int     h;
    pa = '0;
    pb = '1;
    pc = 32'h5a5a_a5a5;
    pd = 32'ha5a5_5a5a;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_LINE_WIDTH;
    cfg_data         = '0;
    src_if.valid     = 1'b0;
    src_if.src_pixel = '0;
    src_if.drain     = 1'b0;
    dst_if.ready     = 1'b0;
    new_palette();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 3x3 frame with corner rules firing, a stray drain up front
    set_frame(3, 3);
    drive(pb, 1'b1);
    script = '{pa, pa, pb, pa, pc, pb, pd, pb, pb};
    feed_frame();

    // 1x1 frame
    settle();
    set_frame(1, 1);
    script = '{pc};
    feed_frame();

    // shrink width and height mid-frame
    settle();
    set_frame(4, 4);
    script = '{pa, pb, pb, pa, pb, pa};
    repeat (6) feed_item();
    settle();
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 2);
    feed_frame();

    // out-of-range registers: zero and above the maximum
    settle();
    new_palette();
    set_frame(0, 2047);
    feed_frame();
    settle();
    new_palette();
    set_frame(3, 0);
    feed_frame();

    while (items_fed < 1400) begin
      settle();
      new_palette();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_frame(w, h);
      if ($urandom_range(0, 5) == 0 && w * (h + 1) > 1) begin
        repeat ($urandom_range(1, w * (h + 1) - 1)) feed_item();
        settle();
        write_reg(REG_LINE_WIDTH, $urandom_range(1, s_w));
        write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 8));
        if (!(s_row == 0 && s_col == 0)) feed_frame();
      end else begin
        feed_frame();
      end
    end

    @(negedge clk);
    src_if.valid = 1'b0;
    while (tracker.pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending_blocks.size() != 0)
      tracker.report($sformatf("%0d blocks never came out", tracker.pending_blocks.size()));
    $display("covered %0d pixel and drain transactions over %0d frames, %0d blocks checked",
             items_fed, frames_fed, tracker.blocks_seen);
    $display("incl. clamped register values, mid-frame resizing and long output stalls");
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
